### hw/rtl/ibp_pkg.sv
// Shared types and constants for the image border padder.
// Beat payload structs, register index codes and fixed field widths.
// No dependencies.
package ibp_pkg;

  localparam int WORD_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // Field widths of the size and pad registers as written
  localparam int WPP_RAW_W = 5;
  localparam int DIM_RAW_W = 11;
  localparam int PAD_RAW_W = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WORDS_PER_PIXEL = 3'd0,
    REG_IMAGE_WIDTH     = 3'd1,
    REG_IMAGE_HEIGHT    = 3'd2,
    REG_PAD_TOP         = 3'd3,
    REG_PAD_BOTTOM      = 3'd4,
    REG_PAD_LEFT        = 3'd5,
    REG_PAD_RIGHT       = 3'd6,
    REG_FILL_WORD       = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic              has_word;
    logic [WORD_W-1:0] source_word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              took_source;
    logic              frame_last;
  } resp_t;

endpackage

### hw/rtl/image_border_padder.sv
// Image border padder: a request beat passes an input register, then a
// result register, before it leaves as a result beat. Throughput is one
// request beat per cycle when the result channel is free; an interior request
// with no source word is retired without result, position counters unchanged.
// Reset (synchronous, active high) clears the row and column counters and
// returns the registers to words_per_pixel = image size = 1, pads and fill 0.
// Depends on ibp_pkg.
module image_border_padder import ibp_pkg::*; #(
  parameter int MAX_IMAGE_DIM       = 1024,
  parameter int MAX_PAD             = 15,
  parameter int MAX_WORDS_PER_PIXEL = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  req_t                   in_data,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output resp_t                  out_data
);

  // Effective caps: the smaller of the parameter and what the field can hold
  localparam int WPP_FIELD_MAX = (1 << WPP_RAW_W) - 1;
  localparam int DIM_FIELD_MAX = (1 << DIM_RAW_W) - 1;
  localparam int PAD_FIELD_MAX = (1 << PAD_RAW_W) - 1;
  localparam int WPP_CAP = (MAX_WORDS_PER_PIXEL < WPP_FIELD_MAX) ?
                           MAX_WORDS_PER_PIXEL : WPP_FIELD_MAX;
  localparam int DIM_CAP = (MAX_IMAGE_DIM < DIM_FIELD_MAX) ? MAX_IMAGE_DIM : DIM_FIELD_MAX;
  localparam int PAD_CAP = (MAX_PAD < PAD_FIELD_MAX) ? MAX_PAD : PAD_FIELD_MAX;

  localparam int SPAN_MAX      = 2 * PAD_CAP + DIM_CAP;
  localparam int ROW_WORDS_MAX = WPP_CAP * SPAN_MAX;

  localparam int WPP_W = $clog2(WPP_CAP + 1);
  localparam int DIM_W = $clog2(DIM_CAP + 1);
  localparam int PAD_W = (PAD_CAP > 0) ? $clog2(PAD_CAP + 1) : 1;
  localparam int ROW_W = $clog2(SPAN_MAX + 1);
  localparam int COL_W = $clog2(ROW_WORDS_MAX + 1);

  // Clamped configuration
  logic [WPP_W-1:0]  wpp, wpp_next;
  logic [DIM_W-1:0]  img_w, img_w_next;
  logic [DIM_W-1:0]  img_h, img_h_next;
  logic [PAD_W-1:0]  pad_t, pad_t_next;
  logic [PAD_W-1:0]  pad_b, pad_b_next;
  logic [PAD_W-1:0]  pad_l, pad_l_next;
  logic [PAD_W-1:0]  pad_r, pad_r_next;
  logic [WORD_W-1:0] fill, fill_next;

  // Frame geometry derived from the configuration
  logic [ROW_W-1:0] body_end, body_end_next;
  logic [ROW_W-1:0] total_rows, total_rows_next;
  logic [COL_W-1:0] left_words, left_words_next;
  logic [COL_W-1:0] mid_end, mid_end_next;
  logic [COL_W-1:0] row_words, row_words_next;

  // Position counters
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  // Pipeline registers
  logic  s1_valid;
  req_t  s1_data;

  // Stage logic
  logic             interior;
  logic             drop;
  logic             out_free;
  logic             s1_adv;
  logic             emit;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_end;
  logic             row_end;

  // Decode a register write and clamp the value into range
  always_comb begin
    wpp_next   = wpp;
    img_w_next = img_w;
    img_h_next = img_h;
    pad_t_next = pad_t;
    pad_b_next = pad_b;
    pad_l_next = pad_l;
    pad_r_next = pad_r;
    fill_next  = fill;
    if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_WORDS_PER_PIXEL: begin
          if (cfg_data[WPP_RAW_W-1:0] == '0) begin
            wpp_next = WPP_W'(1);
          end else if (int'(cfg_data[WPP_RAW_W-1:0]) > WPP_CAP) begin
            wpp_next = WPP_W'(WPP_CAP);
          end else begin
            wpp_next = WPP_W'(cfg_data[WPP_RAW_W-1:0]);
          end
        end
        REG_IMAGE_WIDTH: begin
          if (cfg_data[DIM_RAW_W-1:0] == '0) begin
            img_w_next = DIM_W'(1);
          end else if (int'(cfg_data[DIM_RAW_W-1:0]) > DIM_CAP) begin
            img_w_next = DIM_W'(DIM_CAP);
          end else begin
            img_w_next = DIM_W'(cfg_data[DIM_RAW_W-1:0]);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data[DIM_RAW_W-1:0] == '0) begin
            img_h_next = DIM_W'(1);
          end else if (int'(cfg_data[DIM_RAW_W-1:0]) > DIM_CAP) begin
            img_h_next = DIM_W'(DIM_CAP);
          end else begin
            img_h_next = DIM_W'(cfg_data[DIM_RAW_W-1:0]);
          end
        end
        REG_PAD_TOP: begin
          if (int'(cfg_data[PAD_RAW_W-1:0]) > PAD_CAP) pad_t_next = PAD_W'(PAD_CAP);
          else pad_t_next = PAD_W'(cfg_data[PAD_RAW_W-1:0]);
        end
        REG_PAD_BOTTOM: begin
          if (int'(cfg_data[PAD_RAW_W-1:0]) > PAD_CAP) pad_b_next = PAD_W'(PAD_CAP);
          else pad_b_next = PAD_W'(cfg_data[PAD_RAW_W-1:0]);
        end
        REG_PAD_LEFT: begin
          if (int'(cfg_data[PAD_RAW_W-1:0]) > PAD_CAP) pad_l_next = PAD_W'(PAD_CAP);
          else pad_l_next = PAD_W'(cfg_data[PAD_RAW_W-1:0]);
        end
        REG_PAD_RIGHT: begin
          if (int'(cfg_data[PAD_RAW_W-1:0]) > PAD_CAP) pad_r_next = PAD_W'(PAD_CAP);
          else pad_r_next = PAD_W'(cfg_data[PAD_RAW_W-1:0]);
        end
        REG_FILL_WORD: fill_next = cfg_data[WORD_W-1:0];
      endcase
    end
  end

  // Derive the frame geometry from the incoming configuration
  always_comb begin
    body_end_next   = ROW_W'(pad_t_next) + ROW_W'(img_h_next);
    total_rows_next = body_end_next + ROW_W'(pad_b_next);
    left_words_next = COL_W'(wpp_next) * COL_W'(pad_l_next);
    mid_end_next    = COL_W'(wpp_next) * (COL_W'(pad_l_next) + COL_W'(img_w_next));
    row_words_next  = COL_W'(wpp_next) *
                      (COL_W'(pad_l_next) + COL_W'(img_w_next) + COL_W'(pad_r_next));
  end

  // Hold configuration and geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      wpp        <= WPP_W'(1);
      img_w      <= DIM_W'(1);
      img_h      <= DIM_W'(1);
      pad_t      <= '0;
      pad_b      <= '0;
      pad_l      <= '0;
      pad_r      <= '0;
      fill       <= '0;
      body_end   <= ROW_W'(1);
      total_rows <= ROW_W'(1);
      left_words <= '0;
      mid_end    <= COL_W'(1);
      row_words  <= COL_W'(1);
    end else begin
      wpp        <= wpp_next;
      img_w      <= img_w_next;
      img_h      <= img_h_next;
      pad_t      <= pad_t_next;
      pad_b      <= pad_b_next;
      pad_l      <= pad_l_next;
      pad_r      <= pad_r_next;
      fill       <= fill_next;
      body_end   <= body_end_next;
      total_rows <= total_rows_next;
      left_words <= left_words_next;
      mid_end    <= mid_end_next;
      row_words  <= row_words_next;
    end
  end

  // Classify the current position and find the row and frame ends
  always_comb begin
    interior = (row >= ROW_W'(pad_t)) && (row < body_end) &&
               (col >= left_words) && (col < mid_end);
    drop     = interior && !s1_data.has_word;
    col_inc  = {1'b0, col} + (COL_W+1)'(1);
    row_inc  = {1'b0, row} + (ROW_W+1)'(1);
    col_end  = col_inc >= {1'b0, row_words};
    row_end  = row_inc >= {1'b0, total_rows};
    out_free = !out_valid || out_ready;
    s1_adv   = s1_valid && (drop || out_free);
    emit     = s1_adv && !drop;
  end

  assign in_ready = !s1_valid || s1_adv;

  // Capture request beats
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Advance the position on every emitted word
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (emit) begin
      if (col_end) begin
        col <= '0;
        if (row_end) row <= '0;
        else row <= row_inc[ROW_W-1:0];
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.out_word    <= interior ? s1_data.source_word : fill;
      out_data.took_source <= interior;
      out_data.frame_last  <= col_end && row_end;
    end
  end

  // A closed frame restarts at the top left corner
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && col_end && row_end) |=> (row == '0 && col == '0))
    else $error("counters did not restart after the last word of a frame");

  // A result only moves into a free result register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("result register overwritten while a beat was pending");

  // A retired request without result leaves the position alone
  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && drop) |=> ($stable(row) && $stable(col)))
    else $error("position moved on a request that gave no result");

endmodule

### bench/image_border_padder_tb.sv
// Self-checking testbench for image_border_padder: random bursts of request beats
// against a stalling receiver, checked against a padded-frame position tracker.
// Depends on ibp_pkg and image_border_padder.
module image_border_padder_tb;
  import ibp_pkg::*;

  localparam int unsigned PIPE_LATENCY  = 2;
  localparam int unsigned SETTLE_CYCLES = PIPE_LATENCY + 4;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned TARGET_WORDS  = 1900;

  // Tracks the output position of the padded frame and the words it must produce
  class border_frame_tracker;
    localparam int unsigned MAX_DIM = 1024;
    localparam int unsigned MAX_WPP = 16;

    logic [WPP_RAW_W-1:0] wpp_raw;
    logic [DIM_RAW_W-1:0] width_raw;
    logic [DIM_RAW_W-1:0] height_raw;
    logic [PAD_RAW_W-1:0] pad_top;
    logic [PAD_RAW_W-1:0] pad_bottom;
    logic [PAD_RAW_W-1:0] pad_left;
    logic [PAD_RAW_W-1:0] pad_right;
    logic [WORD_W-1:0]    fill;
    int unsigned          row;
    int unsigned          col_word;
    resp_t                pending_words[$];
    int unsigned          words_predicted;
    int unsigned          mismatches;

    function new();
      wpp_raw         = 1;
      width_raw       = 1;
      height_raw      = 1;
      pad_top         = 0;
      pad_bottom      = 0;
      pad_left        = 0;
      pad_right       = 0;
      fill            = '0;
      row             = 0;
      col_word        = 0;
      words_predicted = 0;
      mismatches      = 0;
    endfunction

    static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Keep only the bits each register holds
    function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WORDS_PER_PIXEL: wpp_raw    = data[WPP_RAW_W-1:0];
        REG_IMAGE_WIDTH:     width_raw  = data[DIM_RAW_W-1:0];
        REG_IMAGE_HEIGHT:    height_raw = data[DIM_RAW_W-1:0];
        REG_PAD_TOP:         pad_top    = data[PAD_RAW_W-1:0];
        REG_PAD_BOTTOM:      pad_bottom = data[PAD_RAW_W-1:0];
        REG_PAD_LEFT:        pad_left   = data[PAD_RAW_W-1:0];
        REG_PAD_RIGHT:       pad_right  = data[PAD_RAW_W-1:0];
        REG_FILL_WORD:       fill       = data[WORD_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the frame position for one accepted request beat
    function void note_request(req_t req);
      int unsigned wpp, w, h, row_words, total_rows, left_words, mid_end;
      bit          interior, last;
      resp_t       r;
      wpp        = clamp(wpp_raw, 1, MAX_WPP);
      w          = clamp(width_raw, 1, MAX_DIM);
      h          = clamp(height_raw, 1, MAX_DIM);
      row_words  = wpp * (pad_left + w + pad_right);
      total_rows = pad_top + h + pad_bottom;
      left_words = wpp * pad_left;
      mid_end    = wpp * (pad_left + w);
      interior   = row >= pad_top && row < pad_top + h &&
                   col_word >= left_words && col_word < mid_end;
      // An interior position with no source word stalls in place
      if (interior && !req.has_word) return;
      last = 1'b0;
      if (col_word + 1 >= row_words) begin
        col_word = 0;
        if (row + 1 >= total_rows) begin
          row  = 0;
          last = 1'b1;
        end else begin
          row++;
        end
      end else begin
        col_word++;
      end
      r.out_word    = interior ? req.source_word : fill;
      r.took_source = interior;
      r.frame_last  = last;
      pending_words.push_back(r);
      words_predicted++;
    endfunction

    function void check_result(resp_t got);
      resp_t want;
      if (pending_words.size() == 0) begin
        $error("result beat with nothing pending: out_word=%h took_source=%b frame_last=%b",
               got.out_word, got.took_source, got.frame_last);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got.out_word !== want.out_word) begin
        $error("out_word: expected %h, got %h", want.out_word, got.out_word);
        mismatches++;
      end
      if (got.took_source !== want.took_source) begin
        $error("took_source: expected %b, got %b", want.took_source, got.took_source);
        mismatches++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %b, got %b", want.frame_last, got.frame_last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_words.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  req_t                   in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  resp_t                  out_data;

  border_frame_tracker frame;

  image_border_padder u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: switch at random between four stall patterns
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(1) == 0);
      2: out_ready <= (rx_tick % 4 == 0);
      default: out_ready <= ($urandom_range(9) < 8);
    endcase
  end

  // Check every result beat
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      frame.check_result(out_data);
    end
  end

  // Give up when no beat moves for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Hold one request beat until accepted, then log it
  task automatic send_word(input logic has_word, input logic [WORD_W-1:0] word);
    req_t req;
    req.has_word    = has_word;
    req.source_word = word;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    frame.note_request(req);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    frame.set_reg(idx, value);
  endtask

  task automatic apply_config(input logic [31:0] wpp, input logic [31:0] width,
                              input logic [31:0] height, input logic [31:0] top,
                              input logic [31:0] bottom, input logic [31:0] left,
                              input logic [31:0] right, input logic [31:0] fill);
    write_reg(REG_WORDS_PER_PIXEL, wpp);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_PAD_TOP, top);
    write_reg(REG_PAD_BOTTOM, bottom);
    write_reg(REG_PAD_LEFT, left);
    write_reg(REG_PAD_RIGHT, right);
    write_reg(REG_FILL_WORD, fill);
    cfg_write <= 1'b0;
  endtask

  // Drain pending words, then let stalled beats clear the pipeline
  task automatic wait_idle();
    while (frame.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Set random bits above a register field some of the time
  function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned w);
    if ($urandom_range(3) != 0) return v;
    return v | ({$urandom} << w);
  endfunction

  // Send bursts of source words with random gaps between them
  task automatic run_phase(input int unsigned n_items);
    int unsigned sent, burst, gap, pick;
    logic [WORD_W-1:0] word;
    sent = 0;
    while (sent < n_items) begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        pick = $urandom_range(15);
        word = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        send_word($urandom_range(99) < 85, word);
        sent++;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned wpp_picks[5];
    int unsigned dim_picks[7];
    int unsigned phase_no;
    wpp_picks = '{0, 1, 16, 17, 31};
    dim_picks = '{0, 1, 2, 1023, 1024, 1025, 2047};
    frame = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset config is a single interior word: no word, then both word extremes
    send_word(1'b0, 32'hDEAD_BEEF);
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b1, 32'hFFFF_FFFF);
    in_valid <= 1'b0;
    wait_idle();

    // Small padded frame: every fourth beat lacks a source word, wherever it falls
    apply_config(1, 2, 2, 1, 1, 1, 1, 32'hA5A5_5A5A);
    for (int i = 0; i < 20; i++) begin
      send_word(i % 4 != 2, i[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
    end
    in_valid <= 1'b0;

    // Random phases, each with its own frame geometry
    phase_no = 0;
    while (frame.words_predicted < TARGET_WORDS) begin
      wait_idle();
      case (phase_no)
        0: apply_config(31, 2047, 2047, 15, 15, 15, 15, 32'hFFFF_FFFF);
        1: apply_config(0, 0, 0, 0, 0, 0, 0, 32'h0000_0000);
        default: begin
          if (phase_no % 4 == 2) begin
            apply_config(wpp_picks[$urandom_range(4)], dim_picks[$urandom_range(6)],
                         dim_picks[$urandom_range(6)], $urandom_range(1) * 15,
                         $urandom_range(1) * 15, $urandom_range(1) * 15,
                         $urandom_range(1) * 15, $urandom);
          end else begin
            apply_config(with_junk($urandom_range(1, 3), WPP_RAW_W),
                         with_junk($urandom_range(1, 4), DIM_RAW_W),
                         with_junk($urandom_range(1, 4), DIM_RAW_W),
                         with_junk($urandom_range($urandom_range(1) ? 3 : 15), PAD_RAW_W),
                         with_junk($urandom_range($urandom_range(1) ? 3 : 15), PAD_RAW_W),
                         with_junk($urandom_range($urandom_range(1) ? 3 : 15), PAD_RAW_W),
                         with_junk($urandom_range($urandom_range(1) ? 3 : 15), PAD_RAW_W),
                         $urandom);
          end
        end
      endcase
      run_phase($urandom_range(20, 150));
      phase_no++;
    end

    wait_idle();
    if (frame.mismatches == 0 && frame.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
